FILE: sv/dssm_pkg.sv
// Package for the dual stack shared memory block.
// Holds request/response types, command and status codes, register map constants.
// No dependencies.
`default_nettype none

package dssm_pkg;

   localparam int unsigned MEM_DEPTH_DEF  = 64;
   localparam int unsigned DATA_WIDTH_DEF = 32;
   localparam int unsigned CNT_W          = 7;
   localparam int unsigned CAP_LIMIT      = (1 << CNT_W) - 1;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(64);

   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic               stack_select;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               top_valid;
      logic signed [31:0] top_value;
      logic [CNT_W-1:0]   lower_count;
      logic [CNT_W-1:0]   upper_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/dssm_ram.sv
// Single-port synchronous RAM holding the entries of both stacks.
// One read or one write per cycle, read data registered. No dependencies.
`default_nettype none

module dssm_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     mem_en,
   input  wire logic                     mem_we,
   input  wire logic [$clog2(DEPTH)-1:0] mem_addr,
   input  wire logic [WIDTH-1:0]         mem_wdata,
   output logic      [WIDTH-1:0]         mem_rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= mem_ff[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/dual_stack_shared_memory.sv
// Top level of the dual stack shared memory block.
// Depends on dssm_pkg and dssm_ram.
`default_nettype none

// Two LIFO stacks share one single-port RAM: the lower stack grows up from entry 0, the upper
// stack grows down from entry capacity-1 (capacity saturates at MEM_DEPTH). The block takes one
// request per clock; each result passes through the s1 and response registers, and a stalled
// response holds the pipeline. Each request makes at most one RAM access (the push write or the
// read of the new top), and a push reports its own value as the top without reading it back.
// The RAM is never cleared; writing the capacity register empties both stacks at once.
module dual_stack_shared_memory
   import dssm_pkg::*;
#(
   parameter int unsigned MEM_DEPTH  = MEM_DEPTH_DEF,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned AW      = $clog2(MEM_DEPTH);
   localparam int unsigned CAP_MAX = (MEM_DEPTH > CAP_LIMIT) ? CAP_LIMIT : MEM_DEPTH;

   typedef struct packed {
      logic [1:0]       status;
      logic             top_ok;
      logic             fwd;
      logic [31:0]      fwd_val;
      logic [CNT_W-1:0] lower;
      logic [CNT_W-1:0] upper;
   } stage_type;

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] lower_depth_ff, lower_depth_in;
   logic [CNT_W-1:0] upper_depth_ff, upper_depth_in;
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0]      cap_eff;
   logic [CNT_W:0]        depth_sum;
   logic                  full;
   logic [CNT_W-1:0]      lower_op, upper_op, sel_depth, top_idx;
   logic [1:0]            status;
   logic                  push_ok, top_ok;
   logic                  cap_wr, req_fire, s1_adv;
   logic                  mem_en, mem_we;
   logic [AW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   // Configuration port
   assign csr_pready = 1'b1;
   assign cap_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) ?
                       CSR_DATA_W'(capacity_ff) : '0;
   assign capacity_in = cap_wr ? csr_pwdata[CNT_W-1:0] : capacity_ff;

   assign cap_eff = (capacity_ff > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : capacity_ff;

   // Handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // Stack operation
   assign depth_sum = {1'b0, lower_depth_ff} + {1'b0, upper_depth_ff};
   assign full      = depth_sum >= {1'b0, cap_eff};
   assign wr_data   = DATA_WIDTH'($signed(req_data.push_value));

   always_comb begin
      lower_op = lower_depth_ff;
      upper_op = upper_depth_ff;
      status   = STAT_DONE;
      push_ok  = 1'b0;
      case (req_data.command)
         CMD_PUSH: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               push_ok = 1'b1;
               if (req_data.stack_select) begin
                  upper_op = upper_depth_ff + 1'b1;
               end else begin
                  lower_op = lower_depth_ff + 1'b1;
               end
            end
         end
         CMD_POP: begin
            if (req_data.stack_select) begin
               if (upper_depth_ff == '0) begin
                  status = STAT_EMPTY;
               end else begin
                  upper_op = upper_depth_ff - 1'b1;
               end
            end else begin
               if (lower_depth_ff == '0) begin
                  status = STAT_EMPTY;
               end else begin
                  lower_op = lower_depth_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      sel_depth = req_data.stack_select ? upper_op : lower_op;
      top_ok    = sel_depth != '0;
      // a push writes exactly the entry that becomes the new top
      top_idx   = req_data.stack_select ? (cap_eff - upper_op) : (lower_op - 1'b1);

      mem_en   = req_fire && top_ok;
      mem_we   = push_ok;
      mem_addr = AW'(top_idx);

      if (cap_wr) begin
         lower_depth_in = '0;
         upper_depth_in = '0;
      end else if (req_fire) begin
         lower_depth_in = lower_op;
         upper_depth_in = upper_op;
      end else begin
         lower_depth_in = lower_depth_ff;
         upper_depth_in = upper_depth_ff;
      end

      s1_in.status  = status;
      s1_in.top_ok  = top_ok;
      s1_in.fwd     = push_ok;
      s1_in.fwd_val = 32'($signed(wr_data));
      s1_in.lower   = lower_op;
      s1_in.upper   = upper_op;

      s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);

      rsp_in.status      = s1_ff.status;
      rsp_in.top_valid   = s1_ff.top_ok;
      rsp_in.top_value   = !s1_ff.top_ok ? '0 :
                           s1_ff.fwd     ? s1_ff.fwd_val : 32'($signed(rd_data));
      rsp_in.lower_count = s1_ff.lower;
      rsp_in.upper_count = s1_ff.upper;

      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   dssm_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (wr_data),
      .mem_rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RESET;
         lower_depth_ff <= '0;
         upper_depth_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         capacity_ff    <= capacity_in;
         lower_depth_ff <= lower_depth_in;
         upper_depth_ff <= upper_depth_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_sum <= {1'b0, cap_eff})
      else $error("stack depths exceed capacity");

   a_full_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STAT_FULL |->
      ({1'b0, rsp_ff.lower_count} + {1'b0, rsp_ff.upper_count}) >= {1'b0, cap_eff})
      else $error("full status with free entries");

   a_push_forward: assert property (@(posedge clock) disable iff (reset)
      req_fire && push_ok |=> s1_valid_ff && s1_ff.fwd && s1_ff.top_ok)
      else $error("push not forwarded as top");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STAT_EMPTY |-> !rsp_ff.top_valid)
      else $error("rejected pop reports a top");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for dual_stack_shared_memory: directed table, then random push/pop/peek traffic
// under several capacity settings, checked against an in-bench model of the two stacks.
// Depends on dssm_pkg and the dual_stack_shared_memory RTL.
`default_nettype none

module tb;
   import dssm_pkg::*;

   localparam logic [1:0] CMD_ALT_PEEK = 2'd3;

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      request;
      logic [6:0]   capacity;
      bit           typed;
      rsp_type      want;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [31:0]  stack_image [MEM_DEPTH_DEF];
   int unsigned  lower_fill = 0;
   int unsigned  upper_fill = 0;
   logic [6:0]   capacity_reg = CAPACITY_RESET;

   rsp_type       expected_results [$];
   table_row_type directed_rows [$];
   bit            steady = 1'b0;
   int unsigned   faults = 0;
   int unsigned   checked = 0;
   int unsigned   requests_sent = 0;
   int unsigned   capacity_writes = 0;
   int unsigned   full_seen = 0;
   int unsigned   empty_seen = 0;

   dual_stack_shared_memory u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("run exceeded time limit with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   function automatic rsp_type stack_step(input req_type r);
      rsp_type     o;
      int unsigned cap;
      int unsigned depth;
      int unsigned slot;
      cap = (capacity_reg > MEM_DEPTH_DEF) ? MEM_DEPTH_DEF : capacity_reg;
      o = '0;
      o.status = STAT_DONE;
      case (r.command)
         CMD_PUSH: begin
            if (lower_fill + upper_fill >= cap) begin
               o.status = STAT_FULL;
            end else if (r.stack_select) begin
               upper_fill++;
               stack_image[(cap - upper_fill) % MEM_DEPTH_DEF] = r.push_value;
            end else begin
               stack_image[lower_fill % MEM_DEPTH_DEF] = r.push_value;
               lower_fill++;
            end
         end
         CMD_POP: begin
            if (r.stack_select) begin
               if (upper_fill == 0) o.status = STAT_EMPTY;
               else upper_fill--;
            end else begin
               if (lower_fill == 0) o.status = STAT_EMPTY;
               else lower_fill--;
            end
         end
         default: ;
      endcase
      depth = r.stack_select ? upper_fill : lower_fill;
      o.top_valid = (depth != 0);
      if (depth != 0) begin
         slot = r.stack_select ? (cap - upper_fill) : (lower_fill - 1);
         o.top_value = stack_image[slot % MEM_DEPTH_DEF];
      end
      o.lower_count = CNT_W'(lower_fill);
      o.upper_count = CNT_W'(upper_fill);
      return o;
   endfunction

   function automatic void add_request(input logic [1:0] cmd, input logic sel,
                                       input logic [31:0] value, input bit typed,
                                       input rsp_type want);
      table_row_type row;
      row.kind = ROW_REQUEST;
      row.request.command = cmd;
      row.request.stack_select = sel;
      row.request.push_value = value;
      row.capacity = '0;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_capacity(input logic [6:0] value);
      table_row_type row;
      row.kind = ROW_CAPACITY;
      row.request = '0;
      row.capacity = value;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic issue(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      if (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = stack_step(r);
      expected_results.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // drop valid and hold until every outstanding result has returned
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_CAPACITY, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      capacity_reg = value;
      lower_fill = 0;
      upper_fill = 0;
      capacity_writes++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result st=%0d v=%0b top=%h lo=%0d up=%0d",
                        rsp_data.status, rsp_data.top_valid, rsp_data.top_value,
                        rsp_data.lower_count, rsp_data.upper_count);
         end else begin
            want = expected_results.pop_front();
            checked++;
            if (rsp_data.status == STAT_FULL) full_seen++;
            if (rsp_data.status == STAT_EMPTY) empty_seen++;
            if (rsp_data.status !== want.status || rsp_data.top_valid !== want.top_valid ||
                rsp_data.top_value !== want.top_value ||
                rsp_data.lower_count !== want.lower_count ||
                rsp_data.upper_count !== want.upper_count) begin
               faults++;
               if (faults <= 10)
                  $display("mismatch on result %0d: want st=%0d v=%0b top=%h lo=%0d up=%0d,",
                           checked, want.status, want.top_valid, want.top_value,
                           want.lower_count, want.upper_count,
                           " got st=%0d v=%0b top=%h lo=%0d up=%0d",
                           rsp_data.status, rsp_data.top_valid, rsp_data.top_value,
                           rsp_data.lower_count, rsp_data.upper_count);
            end
         end
      end
   end

   initial begin : stimulus
      logic [6:0]  plan [8];
      int unsigned eff;
      int unsigned span;
      int unsigned pick;
      bit          filling;
      req_type     r;

      add_request(CMD_PEEK, 1'b0, 32'h0, 1'b1, {STAT_DONE, 1'b0, 32'h0, 7'd0, 7'd0});
      add_request(CMD_POP, 1'b0, 32'h0, 1'b1, {STAT_EMPTY, 1'b0, 32'h0, 7'd0, 7'd0});
      add_request(CMD_POP, 1'b1, 32'h0, 1'b1, {STAT_EMPTY, 1'b0, 32'h0, 7'd0, 7'd0});
      add_request(CMD_PUSH, 1'b0, 32'h7FFF_FFFF, 1'b1,
                  {STAT_DONE, 1'b1, 32'h7FFF_FFFF, 7'd1, 7'd0});
      add_request(CMD_PUSH, 1'b1, 32'h8000_0000, 1'b1,
                  {STAT_DONE, 1'b1, 32'h8000_0000, 7'd1, 7'd1});
      add_request(CMD_PEEK, 1'b1, 32'hFFFF_FFFF, 1'b1,
                  {STAT_DONE, 1'b1, 32'h8000_0000, 7'd1, 7'd1});
      add_request(CMD_ALT_PEEK, 1'b0, 32'h0, 1'b1,
                  {STAT_DONE, 1'b1, 32'h7FFF_FFFF, 7'd1, 7'd1});
      add_request(CMD_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
      add_request(CMD_PUSH, 1'b1, 32'h0, 1'b0, '0);
      add_request(CMD_POP, 1'b0, 32'h0, 1'b0, '0);
      add_request(CMD_POP, 1'b1, 32'h0, 1'b0, '0);
      add_capacity(7'd2);
      add_request(CMD_PUSH, 1'b0, 32'h5555_5555, 1'b1,
                  {STAT_DONE, 1'b1, 32'h5555_5555, 7'd1, 7'd0});
      add_request(CMD_PUSH, 1'b1, 32'hAAAA_AAAA, 1'b1,
                  {STAT_DONE, 1'b1, 32'hAAAA_AAAA, 7'd1, 7'd1});
      add_request(CMD_PUSH, 1'b0, 32'h1, 1'b1, {STAT_FULL, 1'b1, 32'h5555_5555, 7'd1, 7'd1});
      add_request(CMD_PUSH, 1'b1, 32'h1, 1'b1, {STAT_FULL, 1'b1, 32'hAAAA_AAAA, 7'd1, 7'd1});
      add_request(CMD_POP, 1'b1, 32'h0, 1'b0, '0);
      add_request(CMD_PUSH, 1'b0, 32'h1234_5678, 1'b0, '0);
      add_capacity(7'd0);
      add_request(CMD_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b1, {STAT_FULL, 1'b0, 32'h0, 7'd0, 7'd0});
      add_request(CMD_PUSH, 1'b1, 32'h8000_0000, 1'b1, {STAT_FULL, 1'b0, 32'h0, 7'd0, 7'd0});
      add_request(CMD_POP, 1'b1, 32'h0, 1'b1, {STAT_EMPTY, 1'b0, 32'h0, 7'd0, 7'd0});
      add_capacity(7'd127);
      add_request(CMD_PUSH, 1'b1, 32'h0000_0001, 1'b0, '0);
      add_request(CMD_PEEK, 1'b1, 32'h0, 1'b0, '0);
      add_capacity(7'd1);
      add_request(CMD_PUSH, 1'b1, 32'h7FFF_FFFF, 1'b1,
                  {STAT_DONE, 1'b1, 32'h7FFF_FFFF, 7'd0, 7'd1});
      add_request(CMD_PUSH, 1'b0, 32'h0, 1'b1, {STAT_FULL, 1'b0, 32'h0, 7'd0, 7'd1});
      add_request(CMD_ALT_PEEK, 1'b1, 32'h0, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CAPACITY) begin
            settle();
            write_capacity(directed_rows[i].capacity);
         end else begin
            issue(directed_rows[i].request, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      plan = '{7'd64, 7'd7, 7'd1, 7'd127, 7'd0, 7'd33, 7'd96, 7'd2};
      plan[7] = 7'($urandom_range(2, 63));
      for (int p = 0; p < 8; p++) begin
         settle();
         write_capacity(plan[p]);
         eff = (plan[p] > MEM_DEPTH_DEF) ? MEM_DEPTH_DEF : plan[p];
         span = (eff == 0) ? 20 : 2 * eff + 30;
         steady = (p == 3);
         for (int k = 0; k < span; k++) begin
            if (p == 5 && k == span / 2) settle();
            filling = (k < span / 2);
            pick = $urandom_range(99);
            if (pick < (filling ? 65 : 20)) r.command = CMD_PUSH;
            else if (pick < 80) r.command = CMD_POP;
            else if (pick < 93) r.command = CMD_PEEK;
            else r.command = CMD_ALT_PEEK;
            r.stack_select = $urandom_range(1);
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0: r.push_value = 32'h0;
                  1: r.push_value = 32'h7FFF_FFFF;
                  2: r.push_value = 32'h8000_0000;
                  default: r.push_value = 32'hFFFF_FFFF;
               endcase
            end else begin
               r.push_value = $urandom;
            end
            issue(r, 1'b0, '0);
         end
      end
      steady = 1'b0;
      settle();

      $display("sent %0d requests across %0d capacity settings, checked %0d results",
               requests_sent, capacity_writes, checked);
      $display("saw %0d full-memory rejections and %0d empty-stack rejections",
               full_seen, empty_seen);
      if (faults == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results never arrived", faults, expected_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
